### src/ikf_pkg.sv
// Shared constants, types and helpers for the angle Kalman filter
package ikf_pkg;
    localparam int FracBits = 24;
    localparam int RegW = 31;
    localparam int DataW = 32;
    localparam int AddrW = 4;

    localparam logic [RegW-1:0] RstQa = RegW'((((64'd1 << FracBits) + 64'd500) / 64'd1000));
    localparam logic [RegW-1:0] RstQg = RegW'((((64'd3 << FracBits) + 64'd500) / 64'd1000));
    localparam logic [RegW-1:0] RstR = RegW'(64'd1 << (FracBits - 1));
    localparam logic [RegW-1:0] RstDt = RegW'((((64'd1 << FracBits) + 64'd50) / 64'd100));
    localparam logic signed [31:0] FOne = 32'sd1 << FracBits;

    localparam logic [1:0] REG_QA = 2'd0;
    localparam logic [1:0] REG_QG = 2'd1;
    localparam logic [1:0] REG_R = 2'd2;
    localparam logic [1:0] REG_DT = 2'd3;

    typedef struct packed {
        logic signed [31:0] accel_angle;
        logic signed [31:0] gyro_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] corrected_rate;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh7FFFFFFF) r = 32'sh7FFFFFFF;
        else if (v < -66'sh80000000) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction
endpackage

### src/ikf_stream_if.sv
// Valid/ready stream interface
interface ikf_stream_if #(parameter int W = 64);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/ikf_divider.sv
// Restoring signed divider, one quotient bit per cycle, saturated 32-bit result
module ikf_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  ikf_pkg::div_req_t req,
    output ikf_pkg::div_rsp_t rsp
);
    import ikf_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] dmag_reg, dmag_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] nmag;
    logic [33:0] trial;
    logic [64:0] sq;

    always_comb
    begin
        nmag = req.num[63] ? 64'(-req.num) : 64'(req.num);
        quo_next = quo_reg;
        rem_next = rem_reg;
        dmag_next = dmag_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[63]} - {1'b0, dmag_reg};
        if (req.start)
        begin
            quo_next = nmag;
            rem_next = '0;
            dmag_next = req.den[32] ? 33'(-req.den) : 33'(req.den);
            neg_next = req.num[63] ^ req.den[32];
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        sq = neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
        rsp.done = done_reg;
        rsp.quo = sat32(66'(signed'(sq)));
    end
endmodule

### src/imu_angle_kalman_filter_unit.sv
// Top level: one-axis angle/bias Kalman filter with a shared multiplier and divider
//  channel | dir | payload
//  in_s    | in  | accel_angle, gyro_rate (Q8.24)
//  out_s   | out | angle_estimate, corrected_rate (Q8.24)
//  apb     | in  | Q_angle, Q_gyro, R, dt at 0x0..0xC
// Each sample runs 10 products through the one 32x32 multiplier and two divisions for
// the gains, plus prep and output steps. A zero denominator skips both divisions.
// Reset loads default noise and dt values, zero angle/bias and identity covariance.
// Input ready is low from accept until the result is loaded into out_s; a stalled out_s
// holds its beat and keeps the next result, and so the input, waiting.
module imu_angle_kalman_filter_unit (
    input  logic                clk,
    input  logic                rst_n,
    ikf_stream_if.sink          in_s,
    ikf_stream_if.source        out_s,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ikf_pkg::AddrW-1:0] paddr,
    input  logic [ikf_pkg::DataW-1:0] pwdata,
    output logic [ikf_pkg::DataW-1:0] prdata,
    output logic                pready
);
    import ikf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ACC  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_DWT  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_PREP = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic [RegW-1:0] qa_reg, qg_reg, r_reg, dt_reg;
    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] accel_reg, gyro_reg, rate_reg, pang_reg, pd_reg, err_reg;
    logic signed [31:0] q00_reg, q01_reg, q10_reg, q11_reg, k0_reg, k1_reg;
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod_reg;
    logic signed [63:0] fm;
    logic signed [65:0] fmx;
    logic signed [32:0] den;
    div_req_t dreq;
    div_rsp_t drsp;
    out_item_t out_reg;
    logic out_valid_reg;
    in_item_t in_item;
    logic wr_en;

    assign in_item = in_s.data;
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= RstQa;
            qg_reg <= RstQg;
            r_reg <= RstR;
            dt_reg <= RstDt;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_QA: qa_reg <= pwdata[RegW-1:0];
                REG_QG: qg_reg <= pwdata[RegW-1:0];
                REG_R: r_reg <= pwdata[RegW-1:0];
                REG_DT: dt_reg <= pwdata[RegW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_QA: prdata = {1'b0, qa_reg};
            REG_QG: prdata = {1'b0, qg_reg};
            REG_R: prdata = {1'b0, r_reg};
            default: prdata = {1'b0, dt_reg};
        endcase
    end

    // product operand sequence
    always_comb
    begin
        case (step_reg)
            4'd0: begin ma = rate_reg; mb = 32'(dt_reg); end
            4'd1: begin ma = pd_reg; mb = 32'(dt_reg); end
            4'd2: begin ma = p11_reg; mb = 32'(dt_reg); end
            4'd3: begin ma = 32'(qg_reg); mb = 32'(dt_reg); end
            4'd4: begin ma = k0_reg; mb = q00_reg; end
            4'd5: begin ma = k0_reg; mb = q01_reg; end
            4'd6: begin ma = k1_reg; mb = q00_reg; end
            4'd7: begin ma = k1_reg; mb = q01_reg; end
            4'd8: begin ma = k0_reg; mb = err_reg; end
            default: begin ma = k1_reg; mb = err_reg; end
        endcase
    end

    assign fm = prod_reg >>> FracBits;
    assign fmx = 66'(fm);
    assign den = 33'(signed'({1'b0, r_reg})) + 33'(q00_reg);

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num = 64'(q00_reg) <<< FracBits;
        dreq.den = den;
        if (state_reg == S_DIV)
        begin
            dreq.start = (den != '0);
            dreq.num = (step_reg == 4'd0 ? 64'(q00_reg) : 64'(q10_reg)) <<< FracBits;
        end
    end

    ikf_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        case (state_reg)
            S_IDLE: if (in_s.valid) state_next = S_PREP;
            S_PREP: begin state_next = S_MUL; step_next = 4'd0; end
            S_MUL: state_next = S_ACC;
            S_ACC:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd3) begin state_next = S_DIV; step_next = 4'd0; end
                else if (step_reg == 4'd9) state_next = S_OUT;
                else state_next = S_MUL;
            end
            S_DIV: state_next = (den != '0) ? S_DWT : S_DIV;
            S_DWT:
            begin
                if (drsp.done || den == '0)
                begin
                    if (step_reg == 4'd0) begin state_next = S_DIV; step_next = 4'd1; end
                    else begin state_next = S_MUL; step_next = 4'd4; end
                end
            end
            S_OUT: if (!out_valid_reg || out_s.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_DIV && den == '0)
        begin
            state_next = S_MUL;
            step_next = 4'd4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= '0;
            ang_reg <= '0;
            bias_reg <= '0;
            p00_reg <= FOne;
            p01_reg <= '0;
            p10_reg <= '0;
            p11_reg <= FOne;
            out_valid_reg <= 1'b0;
            k0_reg <= '0;
            k1_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            if (state_reg == S_OUT && (!out_valid_reg || out_s.ready)) out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_s.ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    accel_reg <= in_item.accel_angle;
                    gyro_reg <= in_item.gyro_rate;
                end
                S_PREP:
                begin
                    rate_reg <= sat32(66'(gyro_reg) - 66'(bias_reg));
                    pd_reg <= sat32(66'(signed'({1'b0, qa_reg})) - 66'(p01_reg)
                                    - 66'(p10_reg));
                end
                S_MUL: prod_reg <= ma * mb;
                S_ACC:
                begin
                    case (step_reg)
                        4'd0: pang_reg <= sat32(66'(ang_reg) + fmx);
                        4'd1: q00_reg <= sat32(66'(p00_reg) + fmx);
                        4'd2:
                        begin
                            q01_reg <= sat32(66'(p01_reg) - fmx);
                            q10_reg <= sat32(66'(p10_reg) - fmx);
                        end
                        4'd3:
                        begin
                            q11_reg <= sat32(66'(p11_reg) + fmx);
                            err_reg <= sat32(66'(accel_reg) - 66'(pang_reg));
                        end
                        4'd4: p00_reg <= sat32(66'(q00_reg) - fmx);
                        4'd5: p01_reg <= sat32(66'(q01_reg) - fmx);
                        4'd6: p10_reg <= sat32(66'(q10_reg) - fmx);
                        4'd7: p11_reg <= sat32(66'(q11_reg) - fmx);
                        4'd8: ang_reg <= sat32(66'(pang_reg) + fmx);
                        default: bias_reg <= sat32(66'(bias_reg) + fmx);
                    endcase
                end
                S_DIV:
                begin
                    if (den == '0)
                    begin
                        k0_reg <= '0;
                        k1_reg <= '0;
                    end
                end
                S_DWT:
                begin
                    if (drsp.done)
                    begin
                        if (step_reg == 4'd0) k0_reg <= drsp.quo;
                        else k1_reg <= drsp.quo;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_s.ready)
                    begin
                        out_reg.angle_estimate <= ang_reg;
                        out_reg.corrected_rate <= sat32(66'(gyro_reg) - 66'(bias_reg));
                    end
                end
                default: ;
            endcase
        end
    end

    assign in_s.ready = (state_reg == S_IDLE);
    assign out_s.valid = out_valid_reg;
    assign out_s.data = out_reg;

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_s.ready) else $error("ready while busy");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_s.valid && in_s.ready) |=> (state_reg == S_PREP)) else $error("accept lost");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_s.valid && !out_s.ready) |=> $stable(out_s.data)) else $error("out changed");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> (den != '0)) else $error("zero divide");
endmodule
